>>> rtl/fcsm_pkg.sv
package fcsm_pkg;

    localparam int ADDRESS_W = 16;
    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [ADDRESS_W-1:0] CMD_ADDR_A = 16'h5555;
    localparam logic [ADDRESS_W-1:0] CMD_ADDR_B = 16'h2AAA;

    localparam logic [DATA_W-1:0] UNLOCK_A     = 8'hAA;
    localparam logic [DATA_W-1:0] UNLOCK_B     = 8'h55;
    localparam logic [DATA_W-1:0] OP_ERASE     = 8'h80;
    localparam logic [DATA_W-1:0] OP_ID_MODE   = 8'h90;
    localparam logic [DATA_W-1:0] OP_PROGRAM   = 8'hA0;
    localparam logic [DATA_W-1:0] OP_CHIP_ERA  = 8'h10;
    localparam logic [DATA_W-1:0] OP_SECT_ERA  = 8'h30;
    localparam logic [DATA_W-1:0] ERASED_BYTE  = 8'hFF;

    localparam logic [DATA_W-1:0] MFR_ID_RESET = 8'h32;
    localparam logic [DATA_W-1:0] DEV_ID_RESET = 8'h1B;

    typedef enum logic {
        ACT_READ  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MFR_ID = 1'b0,
        REG_DEV_ID = 1'b1
    } cfg_reg_t;

    // command sequencer state as seen by the bus
    typedef enum logic [2:0] {
        CMD_NORMAL  = 3'd0,
        CMD_UNLOCK1 = 3'd1,
        CMD_UNLOCK2 = 3'd2,
        CMD_ERASE_A = 3'd3,
        CMD_ERASE_B = 3'd4,
        CMD_ERASE_C = 3'd5,
        CMD_ID_MODE = 3'd6,
        CMD_PROGRAM = 3'd7
    } cmd_state_t;

    // internal sequencer driving the shared reduce unit and the store
    typedef enum logic [2:0] {
        SQ_CLEAR,
        SQ_IDLE,
        SQ_REDUCE,
        SQ_MEM_DATA,
        SQ_FILL
    } seq_state_t;

    typedef enum logic [1:0] {
        JOB_READ,
        JOB_PROG,
        JOB_SECT_CHECK,
        JOB_SECTOR
    } job_t;

endpackage

>>> rtl/fcsm_if.sv
interface fcsm_req_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [fcsm_pkg::ADDRESS_W-1:0] address;
    logic [fcsm_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, output action, output address, output write_data,
                    input ready);
    modport sink   (input valid, input action, input address, input write_data,
                    output ready);
endinterface

interface fcsm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [fcsm_pkg::DATA_W-1:0] read_data;
    logic                        programmed;

    modport source (output valid, output read_data, output programmed, input ready);
    modport sink   (input valid, input read_data, input programmed, output ready);
endinterface

interface fcsm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fcsm_pkg::CFG_IDX_W-1:0] index;
    logic [fcsm_pkg::DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/flash_command_state_machine.sv
// Channel | Dir | Payload                          | Beat when
// --------+-----+----------------------------------+------------------
// req     | in  | action, address, write_data      | valid & ready
// rsp     | out | read_data, programmed            | valid & ready
// cfg     | in  | index, data (id registers)       | valid & ready
//
// Reads outside normal mode and all non-program writes load their result
// at the beat. Normal reads and programs take address / STORE_BYTES
// compare-subtract steps of the shared reduce unit (0 by default), then read
// the store. Chip erase holds req off while every cell is written with FF
// (one store write per cycle); a sector erase fills up to SECTOR_BYTES cells,
// and only for a SECTOR_BYTES-aligned address. After reset a clearing pass
// zeroes every cell before the first req beat; cfg is taken at any time.
// A stalled rsp holds the result; req is taken again once it leaves.
module flash_command_state_machine #(
    parameter int STORE_BYTES  = 65536,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    fcsm_req_if.sink   req,
    fcsm_rsp_if.source rsp,
    fcsm_cfg_if.sink   cfg
);
    import fcsm_pkg::*;

    localparam int CELL_W = $clog2(STORE_BYTES);
    localparam int RED_W  = ADDRESS_W + 1;
    localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(STORE_BYTES - 1);
    localparam logic [CELL_W:0]   LAST_EXT   = (CELL_W + 1)'(STORE_BYTES - 1);
    localparam logic [CELL_W:0]   SECT_SPAN  = (CELL_W + 1)'(SECTOR_BYTES - 1);
    localparam logic [RED_W-1:0]  STORE_MOD  = RED_W'(STORE_BYTES);
    localparam logic [RED_W-1:0]  SECTOR_MOD = RED_W'(SECTOR_BYTES);

    seq_state_t           seq_reg, seq_next;
    cmd_state_t           cmd_reg, cmd_next;
    job_t                 job_reg, job_next;
    logic [ADDRESS_W-1:0] idx_reg, idx_next;
    logic [CELL_W-1:0]    fill_addr_reg, fill_addr_next;
    logic [CELL_W-1:0]    fill_end_reg, fill_end_next;
    logic                 fill_ff_reg, fill_ff_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    mfr_id_reg, dev_id_reg;

    logic [ADDRESS_W-1:0] addr_reg;
    logic [DATA_W-1:0]    data_reg;
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 prog_reg;

    logic                 out_load;
    logic [DATA_W-1:0]    out_data_d;
    logic                 out_prog_d;

    logic [DATA_W-1:0]    mem [STORE_BYTES];
    logic [DATA_W-1:0]    mem_rdata_reg;
    logic                 mem_we;
    logic [CELL_W-1:0]    mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;
    logic [CELL_W-1:0]    mem_raddr;

    logic                 in_beat, out_beat, cfg_beat;
    logic [RED_W-1:0]     red_mod;
    logic                 red_ge;
    logic [CELL_W:0]      sect_end;

    assign in_beat  = req.valid && req.ready;
    assign out_beat = rsp.valid && rsp.ready;
    assign cfg_beat = cfg.valid && cfg.ready;

    assign req.ready      = (seq_reg == SQ_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = rd_data_reg;
    assign rsp.programmed = prog_reg;
    assign cfg.ready      = 1'b1;

    // shared compare-subtract unit
    assign red_mod  = (job_reg == JOB_SECT_CHECK) ? SECTOR_MOD : STORE_MOD;
    assign red_ge   = {1'b0, idx_reg} >= red_mod;
    assign sect_end = {1'b0, idx_reg[CELL_W-1:0]} + SECT_SPAN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_CLEAR;
            cmd_reg       <= CMD_NORMAL;
            job_reg       <= JOB_READ;
            idx_reg       <= '0;
            fill_addr_reg <= '0;
            fill_end_reg  <= LAST_CELL;
            fill_ff_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            cmd_reg       <= cmd_next;
            job_reg       <= job_next;
            idx_reg       <= idx_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            fill_ff_reg   <= fill_ff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mfr_id_reg <= MFR_ID_RESET;
            dev_id_reg <= DEV_ID_RESET;
        end
        else if (cfg_beat)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_MFR_ID: mfr_id_reg <= cfg.data;
                REG_DEV_ID: dev_id_reg <= cfg.data;
                default:    mfr_id_reg <= mfr_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            addr_reg <= req.address;
            data_reg <= req.write_data;
        end
        if (out_load)
        begin
            rd_data_reg <= out_data_d;
            prog_reg    <= out_prog_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        seq_next       = seq_reg;
        cmd_next       = cmd_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        fill_ff_next   = fill_ff_reg;
        out_valid_next = out_valid_reg && !out_beat;
        out_load       = 1'b0;
        out_data_d     = '0;
        out_prog_d     = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = fill_addr_reg;
        mem_wdata      = fill_ff_reg ? ERASED_BYTE : '0;
        mem_raddr      = idx_reg[CELL_W-1:0];

        unique case (seq_reg)
            SQ_CLEAR, SQ_FILL:
            begin
                mem_we = 1'b1;
                if (fill_addr_reg == fill_end_reg)
                begin
                    seq_next = SQ_IDLE;
                end
                else
                begin
                    fill_addr_next = fill_addr_reg + CELL_W'(1);
                end
            end

            SQ_IDLE:
            begin
                if (in_beat)
                begin
                    idx_next = req.address;
                    if (action_t'(req.action) == ACT_WRITE)
                    begin
                        cmd_next = CMD_NORMAL;
                        unique case (cmd_reg)
                            CMD_NORMAL, CMD_ID_MODE:
                            begin
                                if (req.address == CMD_ADDR_A && req.write_data == UNLOCK_A)
                                    cmd_next = CMD_UNLOCK1;
                            end
                            CMD_UNLOCK1:
                            begin
                                if (req.address == CMD_ADDR_B && req.write_data == UNLOCK_B)
                                    cmd_next = CMD_UNLOCK2;
                            end
                            CMD_UNLOCK2:
                            begin
                                if (req.address == CMD_ADDR_A)
                                begin
                                    if (req.write_data == OP_ERASE)
                                        cmd_next = CMD_ERASE_A;
                                    else if (req.write_data == OP_ID_MODE)
                                        cmd_next = CMD_ID_MODE;
                                    else if (req.write_data == OP_PROGRAM)
                                        cmd_next = CMD_PROGRAM;
                                end
                            end
                            CMD_ERASE_A:
                            begin
                                if (req.address == CMD_ADDR_A && req.write_data == UNLOCK_A)
                                    cmd_next = CMD_ERASE_B;
                            end
                            CMD_ERASE_B:
                            begin
                                if (req.address == CMD_ADDR_B && req.write_data == UNLOCK_B)
                                    cmd_next = CMD_ERASE_C;
                            end
                            CMD_ERASE_C:
                            begin
                                if (req.write_data == OP_CHIP_ERA && req.address == CMD_ADDR_A)
                                begin
                                    fill_addr_next = '0;
                                    fill_end_next  = LAST_CELL;
                                    fill_ff_next   = 1'b1;
                                    seq_next       = SQ_FILL;
                                end
                                else if (req.write_data == OP_SECT_ERA)
                                begin
                                    job_next = JOB_SECT_CHECK;
                                    seq_next = SQ_REDUCE;
                                end
                            end
                            CMD_PROGRAM:
                            begin
                                job_next = JOB_PROG;
                                seq_next = SQ_REDUCE;
                            end
                            default:
                            begin
                                cmd_next = CMD_NORMAL;
                            end
                        endcase
                        // program results come after the store update
                        if (cmd_reg != CMD_PROGRAM)
                        begin
                            out_load       = 1'b1;
                            out_valid_next = 1'b1;
                        end
                    end
                    else if (cmd_reg == CMD_NORMAL)
                    begin
                        job_next = JOB_READ;
                        seq_next = SQ_REDUCE;
                    end
                    else
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        if (cmd_reg == CMD_ID_MODE)
                        begin
                            if (req.address == ADDRESS_W'(0))
                                out_data_d = mfr_id_reg;
                            else if (req.address == ADDRESS_W'(1))
                                out_data_d = dev_id_reg;
                        end
                    end
                end
            end

            SQ_REDUCE:
            begin
                if (red_ge)
                begin
                    idx_next = ADDRESS_W'({1'b0, idx_reg} - red_mod);
                end
                else
                begin
                    case (job_reg)
                        JOB_SECT_CHECK:
                        begin
                            if (idx_reg == '0)
                            begin
                                job_next = JOB_SECTOR;
                                idx_next = addr_reg;
                            end
                            else
                            begin
                                seq_next = SQ_IDLE;
                            end
                        end
                        JOB_SECTOR:
                        begin
                            fill_addr_next = idx_reg[CELL_W-1:0];
                            fill_end_next  = (sect_end > LAST_EXT) ? LAST_CELL
                                                                   : sect_end[CELL_W-1:0];
                            fill_ff_next   = 1'b1;
                            seq_next       = SQ_FILL;
                        end
                        default:
                        begin
                            // store read of the reduced index lands next cycle
                            seq_next = SQ_MEM_DATA;
                        end
                    endcase
                end
            end

            SQ_MEM_DATA:
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
                seq_next       = SQ_IDLE;
                if (job_reg == JOB_PROG)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg[CELL_W-1:0];
                    mem_wdata  = mem_rdata_reg & data_reg;
                    out_prog_d = 1'b1;
                end
                else
                begin
                    out_data_d = mem_rdata_reg;
                end
            end

            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    a_prog_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.programmed |-> rsp.read_data == '0)
        else $error("program result carries read data");

    a_cmd_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_beat && req.action) |=> $stable(cmd_reg))
        else $error("command state moved without a write beat");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SQ_FILL |-> fill_addr_reg <= fill_end_reg)
        else $error("fill address ran past its end");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SQ_MEM_DATA |-> !out_valid_reg)
        else $error("store result would overwrite a pending result");

endmodule
